// File: rtl/yee_es_pkg.sv
package yee_es_pkg;

	localparam int unsigned FIELD_N            = 6;
	localparam int unsigned POS_W              = 11;
	localparam int unsigned CNT_W              = 10;
	localparam int unsigned SCALE_W            = 32;
	localparam int unsigned CFG_DATA_W         = 32;
	localparam int unsigned CFG_INDEX_W        = 2;
	localparam int unsigned SUM_W              = 64;
	localparam int unsigned HALF_W             = 32;
	localparam int unsigned OUT_W              = 63;
	localparam int unsigned WGT_W              = 3;
	localparam int unsigned MAX_CELLS_PER_AXIS = 1024;
	localparam int unsigned SAMPLE_WIDTH_DEF   = 24;
	localparam int unsigned HI_LIMIT_LOG2      = 49;
	localparam int unsigned HI_SHIFT           = 14;
	localparam int unsigned LO_SHIFT           = 18;

	localparam logic [CNT_W-1:0]   CELLS_RESET = CNT_W'(16);
	localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);
	localparam logic [OUT_W-1:0]   OUT_MAX     = '1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_CELLS_X      = 2'd0,
		CFG_CELLS_Y      = 2'd1,
		CFG_CELLS_Z      = 2'd2,
		CFG_ENERGY_SCALE = 2'd3
	} cfg_index_t;

	typedef logic [POS_W-1:0] pos_t;

	typedef struct packed {
		pos_t x;
		pos_t y;
		pos_t z;
	} counts_t;

	typedef struct packed {
		logic [FIELD_N-1:0][WGT_W-1:0] weight;
		logic                          last;
	} cell_info_t;

	typedef logic [FIELD_N-1:0][SUM_W-1:0] sums_t;
	typedef logic [FIELD_N-1:0][OUT_W-1:0] energies_t;

endpackage

// File: rtl/yee_es_sweep.sv
module yee_es_sweep (
	input  logic                   clk,
	input  logic                   arst_n,
	input  yee_es_pkg::counts_t    count,
	input  logic                   advance,
	output yee_es_pkg::cell_info_t info
);
	import yee_es_pkg::*;

	pos_t pos_x_q, pos_y_q, pos_z_q;
	logic in_x, in_y, in_z;
	logic end_x, end_y, end_z;
	logic inside_grid;
	logic [1:0] c_x, c_y, c_z;

	always_comb begin
		in_x  = pos_x_q <= count.x;
		in_y  = pos_y_q <= count.y;
		in_z  = pos_z_q <= count.z;
		end_x = pos_x_q >= count.x + pos_t'(1);
		end_y = pos_y_q >= count.y + pos_t'(1);
		end_z = pos_z_q >= count.z + pos_t'(1);
		inside_grid = (pos_x_q <= count.x + pos_t'(1)) && (pos_y_q <= count.y + pos_t'(1))
			&& (pos_z_q <= count.z + pos_t'(1));
		c_x = 2'(pos_x_q >= pos_t'(2)) + 2'(in_x);
		c_y = 2'(pos_y_q >= pos_t'(2)) + 2'(in_y);
		c_z = 2'(pos_z_q >= pos_t'(2)) + 2'(in_z);
	end

	always_comb begin
		info.weight[0] = (inside_grid && in_x) ? WGT_W'(c_y) * WGT_W'(c_z) : '0;
		info.weight[1] = (inside_grid && in_y) ? WGT_W'(c_x) * WGT_W'(c_z) : '0;
		info.weight[2] = (inside_grid && in_z) ? WGT_W'(c_x) * WGT_W'(c_y) : '0;
		info.weight[3] = (inside_grid && in_y && in_z) ? WGT_W'(c_x) << 1 : '0;
		info.weight[4] = (inside_grid && in_x && in_z) ? WGT_W'(c_y) << 1 : '0;
		info.weight[5] = (inside_grid && in_x && in_y) ? WGT_W'(c_z) << 1 : '0;
		info.last      = end_x && end_y && end_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= pos_t'(1);
			pos_y_q <= pos_t'(1);
			pos_z_q <= pos_t'(1);
		end else if (advance) begin
			if (info.last) begin
				pos_x_q <= pos_t'(1);
				pos_y_q <= pos_t'(1);
				pos_z_q <= pos_t'(1);
			end else if (end_x) begin
				pos_x_q <= pos_t'(1);
				if (end_y) begin
					pos_y_q <= pos_t'(1);
					pos_z_q <= end_z ? pos_t'(1) : pos_z_q + pos_t'(1);
				end else begin
					pos_y_q <= pos_y_q + pos_t'(1);
				end
			end else begin
				pos_x_q <= pos_x_q + pos_t'(1);
			end
		end
	end

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && info.last) |=>
		(pos_x_q == pos_t'(1) && pos_y_q == pos_t'(1) && pos_z_q == pos_t'(1)))
		else $error("positions not restarted after final cell");

endmodule

// File: rtl/yee_es_accum.sv
module yee_es_accum #(
	parameter int unsigned SAMPLE_WIDTH = yee_es_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              in_valid,
	output logic                                              in_ready,
	input  logic [yee_es_pkg::FIELD_N-1:0][SAMPLE_WIDTH-1:0] samples,
	input  yee_es_pkg::cell_info_t                            info,
	output logic                                              res_valid,
	input  logic                                              res_ready,
	output yee_es_pkg::sums_t                                 res_sum
);
	import yee_es_pkg::*;

	localparam int unsigned SQ_W  = 2 * SAMPLE_WIDTH;
	localparam int unsigned WSQ_W = SQ_W + 1;

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		logic [SUM_W:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[SUM_W] ? '1 : t[SUM_W-1:0];
	endfunction

	logic                                  s1_v;
	logic [FIELD_N-1:0][SAMPLE_WIDTH-1:0]  sample_s1;
	cell_info_t                            info_s1;
	logic                                  s2_v;
	logic [FIELD_N-1:0][WSQ_W-1:0]         wsq_s2;
	logic                                  last_s2;
	sums_t                                 sum_q;

	logic                                  s1_ready, s2_ready;
	logic [FIELD_N-1:0][SAMPLE_WIDTH-1:0]  mag;
	logic [FIELD_N-1:0][SQ_W-1:0]          sq;
	logic [FIELD_N-1:0][WSQ_W-1:0]         wsq;
	sums_t                                 new_sum;

	assign s2_ready  = !s2_v || !last_s2 || res_ready;
	assign s1_ready  = !s1_v || s2_ready;
	assign in_ready  = s1_ready;
	assign res_valid = s2_v && last_s2;
	assign res_sum   = new_sum;

	always_comb begin
		for (int f = 0; f < FIELD_N; f++) begin
			mag[f] = sample_s1[f][SAMPLE_WIDTH-1] ? ~sample_s1[f] + 1'b1 : sample_s1[f];
			sq[f]  = SQ_W'(mag[f]) * SQ_W'(mag[f]);
			case (info_s1.weight[f])
				WGT_W'(1): wsq[f] = WSQ_W'(sq[f]);
				WGT_W'(2): wsq[f] = WSQ_W'(sq[f]) << 1;
				WGT_W'(4): wsq[f] = WSQ_W'(sq[f]) << 2;
				default:   wsq[f] = '0;
			endcase
			new_sum[f] = sat_add(sum_q[f], SUM_W'(wsq_s2[f]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v  <= 1'b0;
			s2_v  <= 1'b0;
			sum_q <= '0;
		end else begin
			if (s1_ready) begin
				s1_v <= in_valid;
			end
			if (s2_ready) begin
				s2_v <= s1_v;
			end
			if (s2_v && s2_ready) begin
				sum_q <= last_s2 ? '0 : new_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && s1_ready) begin
			sample_s1 <= samples;
			info_s1   <= info;
		end
		if (s1_v && s2_ready) begin
			wsq_s2  <= wsq;
			last_s2 <= info_s1.last;
		end
	end

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_v && s2_ready && last_s2) |=> (sum_q == '0))
		else $error("sums not cleared after final cell");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v && !s1_ready) |=> (s1_v && $stable(info_s1)))
		else $error("first stage item lost while blocked");

endmodule

// File: rtl/yee_es_scale.sv
module yee_es_scale (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [yee_es_pkg::SCALE_W-1:0]     scale,
	input  logic                               res_valid,
	output logic                               res_ready,
	input  yee_es_pkg::sums_t                  res_sum,
	output logic                               out_valid,
	input  logic                               out_stall,
	output yee_es_pkg::energies_t              energy
);
	import yee_es_pkg::*;

	logic                         s3_v, s4_v, out_v_q;
	sums_t                        sum_s3;
	logic [FIELD_N-1:0][SUM_W-1:0] plo_s4, phi_s4;
	energies_t                    energy_q;

	logic                         out_ready, s4_ready, s3_ready;
	logic [FIELD_N-1:0][SUM_W-1:0] total;
	energies_t                    energy_d;

	assign out_ready = !out_v_q || !out_stall;
	assign s4_ready  = !s4_v || out_ready;
	assign s3_ready  = !s3_v || s4_ready;
	assign res_ready = s3_ready;
	assign out_valid = out_v_q;
	assign energy    = energy_q;

	always_comb begin
		for (int f = 0; f < FIELD_N; f++) begin
			total[f] = (phi_s4[f] << HI_SHIFT) + (plo_s4[f] >> LO_SHIFT);
			if (phi_s4[f][SUM_W-1:HI_LIMIT_LOG2] != '0 || total[f][SUM_W-1]) begin
				energy_d[f] = OUT_MAX;
			end else begin
				energy_d[f] = total[f][OUT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_v    <= 1'b0;
			s4_v    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s3_ready) begin
				s3_v <= res_valid;
			end
			if (s4_ready) begin
				s4_v <= s3_v;
			end
			if (out_ready) begin
				out_v_q <= s4_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && s3_ready) begin
			sum_s3 <= res_sum;
		end
		if (s3_v && s4_ready) begin
			for (int f = 0; f < FIELD_N; f++) begin
				plo_s4[f] <= SUM_W'(sum_s3[f][HALF_W-1:0]) * SUM_W'(scale);
				phi_s4[f] <= SUM_W'(sum_s3[f][SUM_W-1:HALF_W]) * SUM_W'(scale);
			end
		end
		if (s4_v && out_ready) begin
			energy_q <= energy_d;
		end
	end

	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s4_v && !s4_ready) |=> (s4_v && $stable(phi_s4) && $stable(plo_s4)))
		else $error("product stage lost item while output blocked");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(s4_v && out_ready && phi_s4[0][SUM_W-1:HI_LIMIT_LOG2] != '0) |=>
		(energy_q[0] == OUT_MAX))
		else $error("scaled energy not saturated");

endmodule

// File: rtl/yee_grid_field_energy_sum_unit.sv
// Yee lattice field energy accumulator.
// Input channel (in_valid / in_stall): one lattice cell per item, raster order with x
// fastest, each axis over positions 1..n+1, carrying e_x..b_z. An item is taken at an
// edge with in_valid high and in_stall low; one item per cycle unless in_stall is high.
// Output channel (out_valid / out_stall): one item after the final cell of each frame,
// holding the six sums scaled by energy_scale and saturated to 63 bits.
// The final cell passes the sample register, square and weight, accumulate, 32x32
// partial products and combine stages in that order before out_valid rises.
// The six saturating 64-bit accumulators update once per cell in the accumulate stage
// and clear as the final cell's sums move on; positions restart at the final cell.
// A stalled result waits in the output register while the two stages behind it and
// the accumulators keep taking cells; in_stall rises only once a second and third
// result back up behind it and a fourth final cell is held in the accumulate stage.
// Configuration (cfg_write, cfg_index, cfg_data) writes one register per edge; users
// must use it only while idle (not enforced). Writes never touch positions or sums.
// Reset: counts 16, scale 0.25 in Q14.18, positions 1, sums zero, pipeline empty.
module yee_grid_field_energy_sum_unit #(
	parameter int unsigned SAMPLE_WIDTH = yee_es_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [yee_es_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [yee_es_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]        e_x,
	input  logic signed [SAMPLE_WIDTH-1:0]        e_y,
	input  logic signed [SAMPLE_WIDTH-1:0]        e_z,
	input  logic signed [SAMPLE_WIDTH-1:0]        b_x,
	input  logic signed [SAMPLE_WIDTH-1:0]        b_y,
	input  logic signed [SAMPLE_WIDTH-1:0]        b_z,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [yee_es_pkg::OUT_W-1:0]          energy_ex,
	output logic [yee_es_pkg::OUT_W-1:0]          energy_ey,
	output logic [yee_es_pkg::OUT_W-1:0]          energy_ez,
	output logic [yee_es_pkg::OUT_W-1:0]          energy_bx,
	output logic [yee_es_pkg::OUT_W-1:0]          energy_by,
	output logic [yee_es_pkg::OUT_W-1:0]          energy_bz
);
	import yee_es_pkg::*;

	localparam int unsigned CountLim = MAX_CELLS_PER_AXIS - 1;

	logic [CNT_W-1:0]   cells_x_q, cells_y_q, cells_z_q;
	logic [SCALE_W-1:0] energy_scale_q;

	counts_t                              count;
	cell_info_t                           info;
	logic                                 acc_ready, accept;
	logic [FIELD_N-1:0][SAMPLE_WIDTH-1:0] samples;
	logic                                 res_valid, res_ready;
	sums_t                                res_sum;
	energies_t                            energy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_x_q      <= CELLS_RESET;
			cells_y_q      <= CELLS_RESET;
			cells_z_q      <= CELLS_RESET;
			energy_scale_q <= SCALE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_CELLS_X:      cells_x_q      <= cfg_data[CNT_W-1:0];
				CFG_CELLS_Y:      cells_y_q      <= cfg_data[CNT_W-1:0];
				CFG_CELLS_Z:      cells_z_q      <= cfg_data[CNT_W-1:0];
				CFG_ENERGY_SCALE: energy_scale_q <= cfg_data[SCALE_W-1:0];
			endcase
		end
	end

	always_comb begin
		count.x = (32'(cells_x_q) > CountLim) ? POS_W'(CountLim) : POS_W'(cells_x_q);
		count.y = (32'(cells_y_q) > CountLim) ? POS_W'(CountLim) : POS_W'(cells_y_q);
		count.z = (32'(cells_z_q) > CountLim) ? POS_W'(CountLim) : POS_W'(cells_z_q);
	end

	assign samples  = {b_z, b_y, b_x, e_z, e_y, e_x};
	assign accept   = in_valid && acc_ready;
	assign in_stall = !acc_ready;

	yee_es_sweep u_sweep (
		.clk     (clk),
		.arst_n  (arst_n),
		.count   (count),
		.advance (accept),
		.info    (info)
	);

	yee_es_accum #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (acc_ready),
		.samples   (samples),
		.info      (info),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_sum   (res_sum)
	);

	yee_es_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.scale     (energy_scale_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_sum   (res_sum),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.energy    (energy)
	);

	assign energy_ex = energy[0];
	assign energy_ey = energy[1];
	assign energy_ez = energy[2];
	assign energy_bx = energy[3];
	assign energy_by = energy[4];
	assign energy_bz = energy[5];

endmodule
